// ===== hdl/ght_pkg.sv =====
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types and constants for the generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

    localparam int NUM_SLOTS = 256;
    localparam int SLOT_BITS = 8;
    localparam int GEN_BITS  = 16;
    localparam int TAG_BITS  = 32;
    localparam int CNT_BITS  = SLOT_BITS + 1;
    localparam int CMD_BITS  = 2;

    localparam logic [CNT_BITS-1:0] SLOT_LIMIT = CNT_BITS'(NUM_SLOTS);

    // command codes
    localparam logic [CMD_BITS-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_LOOKUP  = 2'd2;

    // input tdata layout
    localparam int IN_TAG_LSB  = 0;
    localparam int IN_SLOT_LSB = IN_TAG_LSB + TAG_BITS;
    localparam int IN_GEN_LSB  = IN_SLOT_LSB + SLOT_BITS;
    localparam int IN_BITS     = IN_GEN_LSB + GEN_BITS;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_SLOT_LSB = 0;
    localparam int OUT_GEN_LSB  = OUT_SLOT_LSB + SLOT_BITS;
    localparam int OUT_TAG_LSB  = OUT_GEN_LSB + GEN_BITS;
    localparam int OUT_BITS     = OUT_TAG_LSB + TAG_BITS;
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic                occupied;
        logic [GEN_BITS-1:0] gen;
    } t_slot_entry;

    // free stack keeps the slot together with its current generation,
    // so allocate needs no slot read
    typedef struct packed {
        logic [SLOT_BITS-1:0] slot;
        logic [GEN_BITS-1:0]  gen;
    } t_stack_entry;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

// ===== hdl/ght_ram.sv =====
// ----------------------------------------------------------------------------
// ght_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/generational_handle_table_top.sv =====
// ----------------------------------------------------------------------------
// generational_handle_table_top
// Generational handle table: allocate, release and lookup of slot handles.
// ----------------------------------------------------------------------------
// An accepted word is registered together with its slot and stack reads; the result
//   word is registered when the output register is free. No new word is taken until
//   that result word is issued, and the slot memory write-back commits with it.
// Reset: clears the free count, the fresh-slot count, the FSM and the output
//   valid; slot and stack memories are not cleared and need no clearing pass.
module generational_handle_table_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // s_axis_tdata: object_tag[31:0], slot_index[39:32], handle_generation[55:40]
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ght_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // s_axis_tuser: cmd[1:0]
    input  logic [ght_pkg::CMD_BITS-1:0]     s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // m_axis_tdata: out_slot[7:0], out_generation[23:8], found_tag[55:24]
    output logic [ght_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // m_axis_tuser: success[0]
    output logic                             m_axis_tuser
);

    localparam int SB = ght_pkg::SLOT_BITS;
    localparam int GB = ght_pkg::GEN_BITS;
    localparam int TB = ght_pkg::TAG_BITS;
    localparam int CB = ght_pkg::CNT_BITS;

    ght_pkg::t_state r_state, n_state;

    logic [CB-1:0] r_free_count, n_free_count;
    logic [CB-1:0] r_used_slots, n_used_slots;

    logic [ght_pkg::CMD_BITS-1:0] r_cmd;
    logic [TB-1:0]                r_tag;
    logic [SB-1:0]                r_slot;
    logic [GB-1:0]                r_gen;

    logic                          r_out_valid, n_out_valid;
    logic [ght_pkg::OUT_TDATA_W-1:0] r_out_tdata, n_out_tdata;
    logic                          r_out_tuser, n_out_tuser;

    logic in_accept;
    logic out_free;
    logic exec_go;

    ght_pkg::t_slot_entry  slot_rdata, slot_wdata;
    ght_pkg::t_stack_entry stk_rdata, stk_wdata;
    logic                  slot_we, stk_we;
    logic [SB-1:0]         slot_waddr, stk_waddr, stk_raddr;
    logic [CB-1:0]         fc_m1;

    // ---------------- FSM ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ght_pkg::ST_IDLE: begin
                if (in_accept) n_state = ght_pkg::ST_EXEC;
            end
            ght_pkg::ST_EXEC: begin
                if (out_free) n_state = ght_pkg::ST_IDLE;
            end
            default: n_state = ght_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ght_pkg::ST_IDLE);
        exec_go       = (r_state == ght_pkg::ST_EXEC) && out_free;
    end

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ght_pkg::ST_IDLE;
            r_free_count <= '0;
            r_used_slots <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_count <= n_free_count;
            r_used_slots <= n_used_slots;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd  <= s_axis_tuser;
            r_tag  <= s_axis_tdata[ght_pkg::IN_TAG_LSB +: TB];
            r_slot <= s_axis_tdata[ght_pkg::IN_SLOT_LSB +: SB];
            r_gen  <= s_axis_tdata[ght_pkg::IN_GEN_LSB +: GB];
        end
        if (exec_go) begin
            r_out_tdata <= n_out_tdata;
            r_out_tuser <= n_out_tuser;
        end
    end

    // ---------------- memories ----------------
    assign fc_m1     = r_free_count - CB'(1);
    assign stk_raddr = fc_m1[SB-1:0];

    ght_ram #(
        .WIDTH ($bits(ght_pkg::t_slot_entry)),
        .DEPTH (ght_pkg::NUM_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_re    (in_accept),
        .i_raddr (s_axis_tdata[ght_pkg::IN_SLOT_LSB +: SB]),
        .o_rdata (slot_rdata)
    );

    ght_ram #(
        .WIDTH ($bits(ght_pkg::t_stack_entry)),
        .DEPTH (ght_pkg::NUM_SLOTS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (in_accept),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // ---------------- execute ----------------
    logic          hit;
    logic [GB-1:0] gen_inc;
    logic [GB-1:0] pop_gen;

    always_comb begin
        hit = (r_gen != '0) && ({1'b0, r_slot} < r_used_slots)
            && (slot_rdata.gen == r_gen) && slot_rdata.occupied;
        gen_inc = slot_rdata.gen + GB'(1);
        if (gen_inc == '0) gen_inc = GB'(1);
        pop_gen = (stk_rdata.gen == '0) ? GB'(1) : stk_rdata.gen;
    end

    always_comb begin
        logic          ok;
        logic [SB-1:0] oslot;
        logic [GB-1:0] ogen;
        logic [TB-1:0] ftag;

        ok           = 1'b0;
        oslot        = '0;
        ogen         = '0;
        ftag         = '0;
        n_free_count = r_free_count;
        n_used_slots = r_used_slots;
        slot_we      = 1'b0;
        slot_waddr   = r_slot;
        slot_wdata   = slot_rdata;
        stk_we       = 1'b0;
        stk_waddr    = r_free_count[SB-1:0];
        stk_wdata.slot = r_slot;
        stk_wdata.gen  = gen_inc;

        unique case (r_cmd)
            ght_pkg::CMD_ALLOC: begin
                if (r_free_count != '0) begin
                    ok           = 1'b1;
                    oslot        = stk_rdata.slot;
                    ogen         = pop_gen;
                    n_free_count = fc_m1;
                end else if (r_used_slots < ght_pkg::SLOT_LIMIT) begin
                    ok           = 1'b1;
                    oslot        = r_used_slots[SB-1:0];
                    ogen         = GB'(1);
                    n_used_slots = r_used_slots + CB'(1);
                end
                slot_we             = ok;
                slot_waddr          = oslot;
                slot_wdata.tag      = r_tag;
                slot_wdata.occupied = 1'b1;
                slot_wdata.gen      = ogen;
            end
            ght_pkg::CMD_RELEASE: begin
                if (hit && (r_free_count < ght_pkg::SLOT_LIMIT)) begin
                    ok           = 1'b1;
                    n_free_count = r_free_count + CB'(1);
                end
                slot_we             = ok;
                slot_wdata.occupied = 1'b0;
                slot_wdata.gen      = gen_inc;
                stk_we              = ok;
            end
            ght_pkg::CMD_LOOKUP: begin
                ok   = hit;
                ftag = hit ? slot_rdata.tag : '0;
            end
            default: begin
                ok = 1'b0;
            end
        endcase

        // counters and writes commit only when the result word is issued
        if (!exec_go) begin
            n_free_count = r_free_count;
            n_used_slots = r_used_slots;
            slot_we      = 1'b0;
            stk_we       = 1'b0;
        end

        n_out_tuser = ok;
        n_out_tdata = '0;
        n_out_tdata[ght_pkg::OUT_SLOT_LSB +: SB] = oslot;
        n_out_tdata[ght_pkg::OUT_GEN_LSB +: GB]  = ogen;
        n_out_tdata[ght_pkg::OUT_TAG_LSB +: TB]  = ftag;
    end

    always_comb begin
        if (exec_go) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;

    // ---------------- assertions ----------------
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= r_used_slots)
        else $error("free stack holds more slots than were handed out");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used_slots <= ght_pkg::SLOT_LIMIT)
        else $error("fresh slot count beyond table size");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ght_pkg::ST_EXEC))
        else $error("accepted word did not enter execute");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ght_pkg::ST_EXEC))
        else $error("result word without an executed command");

endmodule

// ===== tb/generational_handle_table_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// generational_handle_table_top_tb
// Drives allocate, release and lookup words into the handle table and checks
// every result word against a behavioral copy of the table kept in the bench.
// Covers invalid, stale and unoccupied handles, a full table, LIFO reuse and
// generation advance on reuse, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module generational_handle_table_top_tb;

    localparam int NUM_SLOTS    = ght_pkg::NUM_SLOTS;
    localparam int SLOT_BITS    = ght_pkg::SLOT_BITS;
    localparam int GEN_BITS     = ght_pkg::GEN_BITS;
    localparam int TAG_BITS     = ght_pkg::TAG_BITS;
    localparam int CMD_BITS     = ght_pkg::CMD_BITS;
    localparam int IN_TDATA_W   = ght_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W  = ght_pkg::OUT_TDATA_W;
    localparam int IN_TAG_LSB   = ght_pkg::IN_TAG_LSB;
    localparam int IN_SLOT_LSB  = ght_pkg::IN_SLOT_LSB;
    localparam int IN_GEN_LSB   = ght_pkg::IN_GEN_LSB;
    localparam int OUT_SLOT_LSB = ght_pkg::OUT_SLOT_LSB;
    localparam int OUT_GEN_LSB  = ght_pkg::OUT_GEN_LSB;
    localparam int OUT_TAG_LSB  = ght_pkg::OUT_TAG_LSB;

    localparam logic [CMD_BITS-1:0] CMD_UNKNOWN = 2'd3;
    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int RANDOM_WORDS = 300;

    // receiver stall patterns
    localparam int RX_OPEN   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_BURSTY = 2;
    localparam int RX_CHOKE  = 3;

    typedef struct packed {
        logic                 ok;
        logic [SLOT_BITS-1:0] slot;
        logic [GEN_BITS-1:0]  gen;
        logic [TAG_BITS-1:0]  tag;
    } t_handle_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic [CMD_BITS-1:0]     s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tuser;

    // bench copy of the table
    logic [TAG_BITS-1:0]  tbl_tag  [NUM_SLOTS];
    logic                 tbl_busy [NUM_SLOTS];
    logic [GEN_BITS-1:0]  tbl_gen  [NUM_SLOTS];
    logic [SLOT_BITS-1:0] free_slots [NUM_SLOTS];
    int                   free_depth;
    int                   fresh_next;

    t_handle_result pending_results[$];
    int             errors;
    int             cycles = 0;
    int             burst_left;
    bit             sender_paced;
    bit             rx_fast;
    int             rx_mode = RX_OPEN;
    int             rx_tick = 0;

    generational_handle_table_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // applies one word to the bench table and returns the result it must give
    function automatic t_handle_result table_step(input logic [CMD_BITS-1:0]  op,
                                                  input logic [TAG_BITS-1:0]  tag,
                                                  input logic [SLOT_BITS-1:0] slot,
                                                  input logic [GEN_BITS-1:0]  gen);
        t_handle_result       r;
        logic [SLOT_BITS-1:0] s;
        logic [GEN_BITS-1:0]  g_next;
        bit                   hit;
        r   = '0;
        s   = '0;
        hit = (gen != '0) && (int'(slot) < fresh_next) && (tbl_gen[slot] == gen)
              && tbl_busy[slot];
        case (op)
            ght_pkg::CMD_ALLOC: begin
                if (free_depth > 0) begin
                    free_depth--;
                    s = free_slots[free_depth];
                    if (tbl_gen[s] == '0)
                        tbl_gen[s] = GEN_BITS'(1);
                    r.ok = 1'b1;
                end else if (fresh_next < NUM_SLOTS) begin
                    s = SLOT_BITS'(fresh_next);
                    fresh_next++;
                    tbl_gen[s] = GEN_BITS'(1);
                    r.ok = 1'b1;
                end
                if (r.ok) begin
                    tbl_tag[s]  = tag;
                    tbl_busy[s] = 1'b1;
                    r.slot      = s;
                    r.gen       = tbl_gen[s];
                end
            end
            ght_pkg::CMD_RELEASE: begin
                if (hit && free_depth < NUM_SLOTS) begin
                    g_next = tbl_gen[slot] + GEN_BITS'(1);
                    if (g_next == '0)
                        g_next = GEN_BITS'(1);
                    tbl_busy[slot] = 1'b0;
                    tbl_gen[slot]  = g_next;
                    free_slots[free_depth] = slot;
                    free_depth++;
                    r.ok = 1'b1;
                end
            end
            ght_pkg::CMD_LOOKUP: begin
                if (hit) begin
                    r.ok  = 1'b1;
                    r.tag = tbl_tag[slot];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // predict on input accept first, so a same-edge result still finds its entry
    always @(posedge i_clk) begin : result_monitor
        t_handle_result want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                pending_results.insert(pending_results.size(), table_step(s_axis_tuser,
                    s_axis_tdata[IN_TAG_LSB +: TAG_BITS],
                    s_axis_tdata[IN_SLOT_LSB +: SLOT_BITS],
                    s_axis_tdata[IN_GEN_LSB +: GEN_BITS]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result word with no pending operation");
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("success", 32'(want.ok), 32'(m_axis_tuser));
                    check_field("out_slot", 32'(want.slot),
                                32'(m_axis_tdata[OUT_SLOT_LSB +: SLOT_BITS]));
                    check_field("out_generation", 32'(want.gen),
                                32'(m_axis_tdata[OUT_GEN_LSB +: GEN_BITS]));
                    check_field("found_tag", 32'(want.tag),
                                32'(m_axis_tdata[OUT_TAG_LSB +: TAG_BITS]));
                end
            end
        end
    end

    // receiver: picks a random stall pattern, or holds tready high while rx_fast is set
    always @(negedge i_clk) begin
        rx_tick++;
        if (rx_tick % 40 == 0)
            rx_mode = $urandom_range(RX_OPEN, RX_CHOKE);
        if (rx_fast)
            m_axis_tready = 1'b1;
        else begin
            case (rx_mode)
                RX_OPEN:   m_axis_tready = 1'b1;
                RX_COIN:   m_axis_tready = 1'($urandom_range(0, 1));
                RX_BURSTY: m_axis_tready = (rx_tick % 8) < 5;
                default:   m_axis_tready = ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // entered and left at a falling edge, after the table copy has settled
    task automatic send_word(input logic [CMD_BITS-1:0]  op,
                             input logic [TAG_BITS-1:0]  tag,
                             input logic [SLOT_BITS-1:0] slot,
                             input logic [GEN_BITS-1:0]  gen);
        if (sender_paced && burst_left == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        s_axis_tuser = op;
        s_axis_tdata[IN_TAG_LSB +: TAG_BITS]   = tag;
        s_axis_tdata[IN_SLOT_LSB +: SLOT_BITS] = slot;
        s_axis_tdata[IN_GEN_LSB +: GEN_BITS]   = gen;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic wait_all_results();
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [SLOT_BITS-1:0] any_busy_slot();
        logic [SLOT_BITS-1:0] s;
        s = SLOT_BITS'($urandom_range(0, NUM_SLOTS - 1));
        if (fresh_next > 0) begin
            for (int k = 0; k < 8; k++) begin
                s = SLOT_BITS'($urandom_range(0, fresh_next - 1));
                if (tbl_busy[s])
                    break;
            end
        end
        return s;
    endfunction

    task automatic test_basic_ops();
        // empty table: every handle is out of range
        send_word(ght_pkg::CMD_LOOKUP,  32'h1234_5678, 8'd0,   16'd1);
        send_word(ght_pkg::CMD_RELEASE, 32'h0,         8'd0,   16'd1);
        send_word(ght_pkg::CMD_ALLOC,   32'h0,         8'd0,   16'd0);
        send_word(ght_pkg::CMD_ALLOC,   32'hFFFF_FFFF, 8'd0,   16'd0);
        send_word(ght_pkg::CMD_ALLOC,   32'hA5A5_5A5A, 8'd0,   16'd0);
        send_word(ght_pkg::CMD_LOOKUP,  32'h0,         8'd0,   16'd1);
        send_word(ght_pkg::CMD_LOOKUP,  32'h0,         8'd1,   16'd1);
        send_word(ght_pkg::CMD_LOOKUP,  32'h0,         8'd1,   16'd0);      // zero generation
        send_word(ght_pkg::CMD_LOOKUP,  32'h0,         8'd1,   16'hFFFF);   // stale
        send_word(ght_pkg::CMD_LOOKUP,  32'h0,         8'd255, 16'd1);      // beyond fresh
        send_word(ght_pkg::CMD_RELEASE, 32'h0,         8'd255, 16'hFFFF);
        send_word(ght_pkg::CMD_RELEASE, 32'h0,         8'd1,   16'd1);
        send_word(ght_pkg::CMD_LOOKUP,  32'h0,         8'd1,   16'd2);      // free, gen matches
        send_word(ght_pkg::CMD_RELEASE, 32'h0,         8'd1,   16'd2);
        send_word(ght_pkg::CMD_RELEASE, 32'h0,         8'd1,   16'd1);      // double release
        send_word(ght_pkg::CMD_RELEASE, 32'h0,         8'd0,   16'd1);
        send_word(ght_pkg::CMD_ALLOC,   32'h0000_0001, 8'd0,   16'd0);      // LIFO: slot 0 back
        send_word(ght_pkg::CMD_ALLOC,   32'h8000_0000, 8'd0,   16'd0);
        send_word(ght_pkg::CMD_ALLOC,   32'h7FFF_FFFF, 8'd0,   16'd0);      // fresh slot again
        send_word(CMD_UNKNOWN,          32'hFFFF_FFFF, 8'd255, 16'hFFFF);
        send_word(CMD_UNKNOWN,          32'h0,         8'd0,   16'd0);
        send_word(ght_pkg::CMD_LOOKUP,  32'hFFFF_FFFF, 8'd1,   16'd2);
        send_word(ght_pkg::CMD_ALLOC,   32'hC3C3_3C3C, 8'd255, 16'hFFFF);   // slot/gen ignored
        wait_all_results();
    endtask

    task automatic test_random_traffic();
        int                   pick;
        logic [CMD_BITS-1:0]  op;
        logic [TAG_BITS-1:0]  tag;
        logic [SLOT_BITS-1:0] s;
        logic [GEN_BITS-1:0]  g;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 2)
                wait_all_results();
            pick = $urandom_range(0, 99);
            tag  = $urandom;
            s    = any_busy_slot();
            g    = tbl_gen[s];
            op   = (pick < 35) ? ght_pkg::CMD_ALLOC :
                   (pick < 55) ? ght_pkg::CMD_LOOKUP : ght_pkg::CMD_RELEASE;
            if (pick < 35) begin
                s = SLOT_BITS'($urandom);
                g = GEN_BITS'($urandom);
            end else if (pick < 85 && pick >= 75) begin
                g = g ^ GEN_BITS'($urandom_range(1, 65535));
            end else if (pick < 90 && pick >= 85) begin
                g = '0;
            end else if (pick < 95 && pick >= 90) begin
                if (fresh_next < NUM_SLOTS)
                    s = SLOT_BITS'($urandom_range(fresh_next, NUM_SLOTS - 1));
            end else if (pick >= 95) begin
                op = CMD_BITS'($urandom);
                s  = SLOT_BITS'($urandom);
                g  = GEN_BITS'($urandom);
            end
            if (pick >= 75 && pick < 95 && $urandom_range(0, 1))
                op = ght_pkg::CMD_LOOKUP;
            send_word(op, tag, s, g);
        end
        wait_all_results();
    endtask

    task automatic test_table_full();
        while (fresh_next < NUM_SLOTS || free_depth > 0)
            send_word(ght_pkg::CMD_ALLOC, $urandom, SLOT_BITS'($urandom),
                      GEN_BITS'($urandom));
        repeat (3) send_word(ght_pkg::CMD_ALLOC, $urandom, SLOT_BITS'($urandom),
                             GEN_BITS'($urandom));
        send_word(ght_pkg::CMD_LOOKUP,  32'h0, 8'd255, tbl_gen[255]);
        send_word(ght_pkg::CMD_RELEASE, 32'h0, 8'd255, tbl_gen[255]);
        send_word(ght_pkg::CMD_ALLOC,   32'hFFFF_FFFF, 8'd0, 16'd0);
        send_word(ght_pkg::CMD_ALLOC,   32'h0, 8'd0, 16'd0);
        wait_all_results();
    endtask

    // cycle one slot through release/allocate, back to back, so its generation
    // steps up on every reuse
    task automatic test_slot_reuse();
        logic [GEN_BITS-1:0] g;
        sender_paced = 1'b0;
        rx_fast      = 1'b1;
        repeat (8) begin
            g = tbl_gen[0];
            send_word(ght_pkg::CMD_RELEASE, 32'h0, 8'd0, g);
            send_word(ght_pkg::CMD_ALLOC, $urandom, 8'd0, 16'd0);
        end
        send_word(ght_pkg::CMD_LOOKUP, 32'h0, 8'd0, tbl_gen[0]);
        send_word(ght_pkg::CMD_LOOKUP, 32'h0, 8'd0, 16'd1);
        wait_all_results();
        sender_paced = 1'b1;
        rx_fast      = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ght_pkg::CMD_ALLOC;
        errors        = 0;
        burst_left    = 0;
        sender_paced  = 1'b1;
        rx_fast       = 1'b0;
        free_depth    = 0;
        fresh_next    = 0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            tbl_tag[k]    = '0;
            tbl_busy[k]   = 1'b0;
            tbl_gen[k]    = '0;
            free_slots[k] = '0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic_ops();
        test_random_traffic();
        test_table_full();
        test_slot_reuse();

        wait_all_results();
        repeat (20) @(negedge i_clk);
        if (pending_results.size() != 0)
            errors++;
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
